>>> src/obs_pkg.sv
`timescale 1ns / 1ps

package obs_pkg;

  localparam int CoordW    = 20;
  localparam int AxisW     = 16;
  localparam int HalfW     = 20;
  localparam int TagW      = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = DiffW + AxisW;
  localparam int DotW      = ProdW + 1;
  localparam int AxisFrac  = 14;
  localparam int ClampW    = HalfW + AxisFrac + 1;
  localparam int WProdW    = ClampW + AxisW;
  localparam int ErrW      = WProdW + 2;
  localparam int DiffShift = 28;
  localparam int FracShift = 24;
  localparam int RndW      = ErrW - FracShift;
  localparam int SqW       = 2 * RndW - 1;
  localparam int SumW      = SqW + 2;
  localparam int RadSqW    = 2 * CoordW;
  localparam int RadShift  = 8;

  localparam int CfgAddrW  = 6;
  localparam int CfgDataW  = 64;
  localparam int CenterW   = 3 * CoordW;
  localparam int AxisRegW  = 3 * AxisW;
  localparam int HalfRegW  = 3 * HalfW;

  localparam logic signed [ErrW-1:0] RoundBias = ErrW'(64'd1 << (FracShift - 1));

  localparam logic [AxisRegW-1:0] Axis0Reset = AxisRegW'(64'd16384);
  localparam logic [AxisRegW-1:0] Axis1Reset = AxisRegW'(64'd1073741824);
  localparam logic [AxisRegW-1:0] Axis2Reset = AxisRegW'(64'd70368744177664);

  typedef enum logic [2:0] {
    RegCenter   = 3'd0,
    RegAxis0    = 3'd1,
    RegAxis1    = 3'd2,
    RegAxis2    = 3'd3,
    RegHalfSize = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CenterW-1:0]           center;
    logic [2:0][AxisRegW-1:0]     axis;
    logic [HalfRegW-1:0]          half_size;
  } box_cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] radius;
    logic [TagW-1:0]   tag;
    logic              last;
  } sphere_t;

  typedef struct packed {
    logic [2:0][DiffW-1:0]  d;
    logic [2:0][ClampW-1:0] pc;
    logic [RadSqW-1:0]      r2;
    logic [TagW-1:0]        tag;
    logic                   last;
  } proj_t;

  typedef struct packed {
    logic            hit;
    logic [TagW-1:0] tag;
    logic            last;
  } result_t;

  function automatic logic signed [AxisW-1:0] get_axis(box_cfg_t cfg, int unsigned i,
                                                       int unsigned c);
    return $signed(cfg.axis[i][c*AxisW +: AxisW]);
  endfunction

endpackage

>>> src/obs_cfg_regs.sv
`timescale 1ns / 1ps

module obs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [obs_pkg::CfgDataW-1:0]  pwdata,
  output logic [obs_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output obs_pkg::box_cfg_t             cfg_o
);

  obs_pkg::box_cfg_t cfg_q, cfg_d;
  obs_pkg::cfg_reg_e sel;
  logic              wr_en;

  assign sel    = obs_pkg::cfg_reg_e'(paddr[5:3]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        obs_pkg::RegCenter:   cfg_d.center    = pwdata[obs_pkg::CenterW-1:0];
        obs_pkg::RegAxis0:    cfg_d.axis[0]   = pwdata[obs_pkg::AxisRegW-1:0];
        obs_pkg::RegAxis1:    cfg_d.axis[1]   = pwdata[obs_pkg::AxisRegW-1:0];
        obs_pkg::RegAxis2:    cfg_d.axis[2]   = pwdata[obs_pkg::AxisRegW-1:0];
        obs_pkg::RegHalfSize: cfg_d.half_size = pwdata[obs_pkg::HalfRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      obs_pkg::RegCenter:   prdata = obs_pkg::CfgDataW'(cfg_q.center);
      obs_pkg::RegAxis0:    prdata = obs_pkg::CfgDataW'(cfg_q.axis[0]);
      obs_pkg::RegAxis1:    prdata = obs_pkg::CfgDataW'(cfg_q.axis[1]);
      obs_pkg::RegAxis2:    prdata = obs_pkg::CfgDataW'(cfg_q.axis[2]);
      obs_pkg::RegHalfSize: prdata = obs_pkg::CfgDataW'(cfg_q.half_size);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center    <= '0;
      cfg_q.axis[0]   <= obs_pkg::Axis0Reset;
      cfg_q.axis[1]   <= obs_pkg::Axis1Reset;
      cfg_q.axis[2]   <= obs_pkg::Axis2Reset;
      cfg_q.half_size <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/obs_proj.sv
`timescale 1ns / 1ps

// Stages 1-4: offset, axis products, dot sums, clamp to half size.
module obs_proj (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obs_pkg::box_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  obs_pkg::sphere_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output obs_pkg::proj_t    out_o
);

  logic [3:0] v_q;
  logic [3:0] adv;

  logic signed [obs_pkg::DiffW-1:0]  d1_q [3];
  logic signed [obs_pkg::DiffW-1:0]  d2_q [3];
  logic signed [obs_pkg::DiffW-1:0]  d3_q [3];
  logic signed [obs_pkg::DiffW-1:0]  d4_q [3];
  logic signed [obs_pkg::ProdW-1:0]  prod_q [3][3];
  logic signed [obs_pkg::DotW-1:0]   dot_q [3];
  logic signed [obs_pkg::ClampW-1:0] pc_q [3];

  logic [obs_pkg::RadSqW-1:0] r2_q [4];
  logic [obs_pkg::TagW-1:0]   tag_q [4];
  logic                       last_q [4];

  logic signed [obs_pkg::AxisW-1:0]  ax [3][3];
  logic signed [obs_pkg::CoordW-1:0] sph [3];
  logic signed [obs_pkg::CoordW-1:0] ctr [3];
  logic signed [obs_pkg::DiffW-1:0]  d_d [3];
  logic signed [obs_pkg::DotW-1:0]   dot_d [3];
  logic signed [obs_pkg::DotW-1:0]   lim [3];
  logic signed [obs_pkg::DotW-1:0]   clip [3];

  assign sph[0] = $signed(in_i.x);
  assign sph[1] = $signed(in_i.y);
  assign sph[2] = $signed(in_i.z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr[i] = $signed(cfg_i.center[i*obs_pkg::CoordW +: obs_pkg::CoordW]);
      d_d[i] = obs_pkg::DiffW'(sph[i]) - obs_pkg::DiffW'(ctr[i]);
      for (int c = 0; c < 3; c++) begin
        ax[i][c] = obs_pkg::get_axis(cfg_i, i, c);
      end
      dot_d[i] = prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
      lim[i] = $signed({4'b0000, cfg_i.half_size[i*obs_pkg::HalfW +: obs_pkg::HalfW],
                        {obs_pkg::AxisFrac{1'b0}}});
      if (dot_q[i] > lim[i]) begin
        clip[i] = lim[i];
      end else if (dot_q[i] < -lim[i]) begin
        clip[i] = -lim[i];
      end else begin
        clip[i] = dot_q[i];
      end
    end
  end

  // a stage moves on when empty or when its successor moves on
  assign adv[3] = ~v_q[3] | out_ready_i;
  assign adv[2] = ~v_q[2] | adv[3];
  assign adv[1] = ~v_q[1] | adv[2];
  assign adv[0] = ~v_q[0] | adv[1];
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d1_q      <= d_d;
      r2_q[0]   <= in_i.radius * in_i.radius;
      tag_q[0]  <= in_i.tag;
      last_q[0] <= in_i.last;
    end
    if (adv[1]) begin
      d2_q <= d1_q;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[i][c] <= d1_q[c] * ax[i][c];
        end
      end
      r2_q[1]   <= r2_q[0];
      tag_q[1]  <= tag_q[0];
      last_q[1] <= last_q[0];
    end
    if (adv[2]) begin
      d3_q      <= d2_q;
      dot_q     <= dot_d;
      r2_q[2]   <= r2_q[1];
      tag_q[2]  <= tag_q[1];
      last_q[2] <= last_q[1];
    end
    if (adv[3]) begin
      d4_q <= d3_q;
      for (int i = 0; i < 3; i++) begin
        pc_q[i] <= clip[i][obs_pkg::ClampW-1:0];
      end
      r2_q[3]   <= r2_q[2];
      tag_q[3]  <= tag_q[2];
      last_q[3] <= last_q[2];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_o.d[i]  = d4_q[i];
      out_o.pc[i] = pc_q[i];
    end
    out_o.r2   = r2_q[3];
    out_o.tag  = tag_q[3];
    out_o.last = last_q[3];
  end

  assign out_valid_o = v_q[3];

endmodule

>>> src/obs_dist.sv
`timescale 1ns / 1ps

// Stages 5-8: closest point offset, rounding, squares, radius compare.
module obs_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obs_pkg::box_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  obs_pkg::proj_t    in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output obs_pkg::result_t  out_o
);

  logic [3:0] v_q;
  logic [3:0] adv;

  logic signed [obs_pkg::WProdW-1:0] wp_q [3][3];
  logic signed [obs_pkg::DiffW-1:0]  d5_q [3];
  logic signed [obs_pkg::RndW-1:0]   q_q [3];
  logic        [obs_pkg::SqW-1:0]    sq_q [3];
  logic                              hit_q;

  logic [obs_pkg::RadSqW-1:0] r2_q [3];
  logic [obs_pkg::TagW-1:0]   tag_q [4];
  logic                       last_q [4];

  logic signed [obs_pkg::AxisW-1:0]    ax [3][3];
  logic signed [obs_pkg::ErrW-1:0]     err [3];
  logic signed [2*obs_pkg::RndW-1:0]   sq_full [3];
  logic        [obs_pkg::SumW-1:0]     dist2;
  logic        [obs_pkg::SumW-1:0]     rad2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        ax[i][c] = obs_pkg::get_axis(cfg_i, i, c);
      end
    end
    for (int c = 0; c < 3; c++) begin
      // closest point minus sphere center, biased so the shift rounds half up
      err[c] = -$signed({{(obs_pkg::ErrW-obs_pkg::DiffW-obs_pkg::DiffShift){d5_q[c][
                 obs_pkg::DiffW-1]}}, d5_q[c], {obs_pkg::DiffShift{1'b0}}})
               + obs_pkg::ErrW'(wp_q[0][c]) + obs_pkg::ErrW'(wp_q[1][c])
               + obs_pkg::ErrW'(wp_q[2][c]) + obs_pkg::RoundBias;
      sq_full[c] = q_q[c] * q_q[c];
    end
    dist2 = obs_pkg::SumW'(sq_q[0]) + obs_pkg::SumW'(sq_q[1]) + obs_pkg::SumW'(sq_q[2]);
    rad2  = obs_pkg::SumW'({r2_q[2], {obs_pkg::RadShift{1'b0}}});
  end

  assign adv[3] = ~v_q[3] | out_ready_i;
  assign adv[2] = ~v_q[2] | adv[3];
  assign adv[1] = ~v_q[1] | adv[2];
  assign adv[0] = ~v_q[0] | adv[1];
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        d5_q[i] <= $signed(in_i.d[i]);
        for (int c = 0; c < 3; c++) begin
          wp_q[i][c] <= ax[i][c] * $signed(in_i.pc[i]);
        end
      end
      r2_q[0]   <= in_i.r2;
      tag_q[0]  <= in_i.tag;
      last_q[0] <= in_i.last;
    end
    if (adv[1]) begin
      for (int c = 0; c < 3; c++) begin
        q_q[c] <= err[c][obs_pkg::ErrW-1:obs_pkg::FracShift];
      end
      r2_q[1]   <= r2_q[0];
      tag_q[1]  <= tag_q[0];
      last_q[1] <= last_q[0];
    end
    if (adv[2]) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= sq_full[c][obs_pkg::SqW-1:0];
      end
      r2_q[2]   <= r2_q[1];
      tag_q[2]  <= tag_q[1];
      last_q[2] <= last_q[1];
    end
    if (adv[3]) begin
      hit_q     <= (dist2 <= rad2);
      tag_q[3]  <= tag_q[2];
      last_q[3] <= last_q[2];
    end
  end

  assign out_o.hit   = hit_q;
  assign out_o.tag   = tag_q[3];
  assign out_o.last  = last_q[3];
  assign out_valid_o = v_q[3];

endmodule

>>> src/obb_sphere_overlap_test.sv
`timescale 1ns / 1ps

// Oriented box versus sphere overlap tester.
// The box (center, three axes, three half sizes) is written through the APB
// port at byte addresses 0, 8, 16, 24 and 32; write it only while no sphere
// is in flight. Reads return the register contents, pready is always high.
// Spheres arrive on the slave stream: tdata carries x, y, z, radius (signed
// and unsigned Q12.8) and the tag, tlast carries the batch end flag.
// Each sphere yields one beat on the master stream: hit (touching counts),
// the tag and tlast copied from the input.
// An accepted beat passes four stages of projection and clamping, then four
// of closest point, squaring and compare.
// Throughput is one sphere per cycle while m_axis_tready stays high; every stage holds one beat.
// Reset empties the pipeline and loads the default box: center at the
// origin, axes along x, y and z, half sizes zero.
// When the receiver stalls, the output beat holds and each stage keeps its
// beat; empty stages still fill, so tready drops only once all are full.
module obb_sphere_overlap_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [obs_pkg::CfgDataW-1:0]  pwdata,
  output logic [obs_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sphere_x[19:0], sphere_y[39:20], sphere_z[59:40], sphere_radius[79:60],
  // item_tag[95:80]
  input  logic [95:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit[0], hit_tag[16:1], zero fill[23:17]
  output logic [23:0]                   m_axis_tdata,
  output logic                          m_axis_tlast
);

  obs_pkg::box_cfg_t cfg;
  obs_pkg::sphere_t  sphere;
  obs_pkg::proj_t    proj;
  obs_pkg::result_t  res;
  logic              proj_valid;
  logic              proj_ready;

  assign sphere.x      = s_axis_tdata[19:0];
  assign sphere.y      = s_axis_tdata[39:20];
  assign sphere.z      = s_axis_tdata[59:40];
  assign sphere.radius = s_axis_tdata[79:60];
  assign sphere.tag    = s_axis_tdata[95:80];
  assign sphere.last   = s_axis_tlast;

  obs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  obs_proj u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (sphere),
    .out_valid_o (proj_valid),
    .out_ready_i (proj_ready),
    .out_o       (proj)
  );

  obs_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (proj_valid),
    .in_ready_o  (proj_ready),
    .in_i        (proj),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {7'b0000000, res.tag, res.hit};
  assign m_axis_tlast = res.last;

endmodule

>>> verif/tb_obb_sphere_overlap_test.sv
`timescale 1ns / 1ps

module tb_obb_sphere_overlap_test;

  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 12;
  localparam int NumPhases   = 7;
  localparam int PhaseItems  = 220;

  typedef struct packed {
    logic [19:0] x;
    logic [19:0] y;
    logic [19:0] z;
    logic [19:0] radius;
    logic [15:0] tag;
    logic        last;
  } sphere_beat_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] tag;
    logic        last;
  } overlap_result_t;

  class box_hit_predictor;
    logic [59:0]     center;
    logic [47:0]     axis [3];
    logic [59:0]     half_size;
    overlap_result_t hits_due [$];
    int unsigned     mismatches;

    function new();
      center    = '0;
      axis[0]   = 48'h0000_0000_4000;
      axis[1]   = 48'h0000_4000_0000;
      axis[2]   = 48'h4000_0000_0000;
      half_size = '0;
      mismatches = 0;
    endfunction

    function void set_reg(obs_pkg::cfg_reg_e idx, logic [63:0] value);
      case (idx)
        obs_pkg::RegCenter:   center    = value[59:0];
        obs_pkg::RegAxis0:    axis[0]   = value[47:0];
        obs_pkg::RegAxis1:    axis[1]   = value[47:0];
        obs_pkg::RegAxis2:    axis[2]   = value[47:0];
        obs_pkg::RegHalfSize: half_size = value[59:0];
        default: ;
      endcase
    endfunction

    // Closest box point to the sphere center, exact until one rounding to Q.12
    function void note_sphere(sphere_beat_t s);
      longint      d [3];
      longint      err [3];
      longint      ax [3][3];
      longint      proj, lim, q, dist2, rad2;
      logic [19:0] coord [3];
      coord[0] = s.x;
      coord[1] = s.y;
      coord[2] = s.z;
      dist2 = 0;
      for (int c = 0; c < 3; c++) begin
        d[c]   = longint'($signed(coord[c])) - longint'($signed(center[20*c +: 20]));
        err[c] = -(d[c] <<< 28);
      end
      for (int i = 0; i < 3; i++)
        for (int c = 0; c < 3; c++)
          ax[i][c] = longint'($signed(axis[i][16*c +: 16]));
      for (int i = 0; i < 3; i++) begin
        lim  = longint'(half_size[20*i +: 20]) <<< 14;
        proj = d[0] * ax[i][0] + d[1] * ax[i][1] + d[2] * ax[i][2];
        if (proj > lim) proj = lim;
        if (proj < -lim) proj = -lim;
        for (int c = 0; c < 3; c++) err[c] += ax[i][c] * proj;
      end
      for (int c = 0; c < 3; c++) begin
        q = (err[c] + (longint'(1) <<< 23)) >>> 24;
        dist2 += q * q;
      end
      rad2 = (longint'(s.radius) * longint'(s.radius)) <<< 8;
      hits_due.push_back(overlap_result_t'{dist2 <= rad2, s.tag, s.last});
    endfunction

    function void check_result(overlap_result_t got);
      overlap_result_t want;
      if (hits_due.size() == 0) begin
        $error("result beat with tag %0h arrived with nothing pending", got.tag);
        mismatches++;
        return;
      end
      want = hits_due.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b (tag %0h)", want.hit, got.hit, want.tag);
        mismatches++;
      end
      if (got.tag !== want.tag) begin
        $error("hit_tag: expected %0h, actual %0h", want.tag, got.tag);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_of_batch: expected %0b, actual %0b (tag %0h)", want.last, got.last,
               want.tag);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [obs_pkg::CfgAddrW-1:0] paddr;
  logic [obs_pkg::CfgDataW-1:0] pwdata;
  logic [obs_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // sphere_x[19:0], sphere_y[39:20], sphere_z[59:40], sphere_radius[79:60],
  // item_tag[95:80]
  logic [95:0]                  s_axis_tdata;
  logic                         s_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // hit[0], hit_tag[16:1], zero fill[23:17]
  logic [23:0]                  m_axis_tdata;
  logic                         m_axis_tlast;

  box_hit_predictor box_model = new();

  bit          steady_tx;
  bit          steady_rx;
  longint      box_ctr [3];
  longint      box_half [3];
  int unsigned radius_cap;
  logic [47:0] spun [3];
  int unsigned quiet_cycles = 0;

  obb_sphere_overlap_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(3, 1);
    if (roll < 92) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic longint rand_offset(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  function automatic logic [59:0] random_center(int unsigned units);
    logic [59:0] packed_ctr;
    for (int c = 0; c < 3; c++)
      packed_ctr[20*c +: 20] = 20'(rand_offset(longint'(units) * 256));
    return packed_ctr;
  endfunction

  function automatic logic [59:0] random_half(int unsigned units);
    logic [59:0] packed_half;
    for (int c = 0; c < 3; c++) packed_half[20*c +: 20] = 20'($urandom_range(units * 256));
    return packed_half;
  endfunction

  function automatic logic [15:0] to_q14(real v);
    return 16'($rtoi(v * 16384.0 + (v < 0.0 ? -0.5 : 0.5)));
  endfunction

  // Orthonormal frame from two random angles, x component lowest
  function automatic void pick_rotation();
    real a, b, ca, sa, cb, sb;
    a  = $urandom_range(359) * 3.14159265358979 / 180.0;
    b  = $urandom_range(359) * 3.14159265358979 / 180.0;
    ca = $cos(a);
    sa = $sin(a);
    cb = $cos(b);
    sb = $sin(b);
    spun[0] = {to_q14(-sb), to_q14(sa * cb), to_q14(ca * cb)};
    spun[1] = {to_q14(0.0), to_q14(ca), to_q14(-sa)};
    spun[2] = {to_q14(cb), to_q14(sa * sb), to_q14(ca * sb)};
  endfunction

  function automatic sphere_beat_t mk_sphere(int x, int y, int z, int unsigned r,
                                             int unsigned tag, bit last);
    return sphere_beat_t'{20'(x), 20'(y), 20'(z), 20'(r), 16'(tag), last};
  endfunction

  function automatic sphere_beat_t random_sphere();
    sphere_beat_t s;
    longint       pos [3];
    int           roll;
    int           k;
    roll     = $urandom_range(99);
    s.radius = 20'($urandom_range(radius_cap));
    if ($urandom_range(99) < 5) s.radius = '0;
    else if ($urandom_range(99) < 2) s.radius = '1;
    s.tag  = 16'($urandom);
    s.last = ($urandom_range(7) == 0);
    if (roll < 15) begin
      s.x      = 20'($urandom);
      s.y      = 20'($urandom);
      s.z      = 20'($urandom);
      s.radius = 20'($urandom);
    end else begin
      if (roll < 40) begin
        // sit just off one face, within one LSB of an exact touch for an axis-aligned box
        k = $urandom_range(2);
        for (int c = 0; c < 3; c++) pos[c] = box_ctr[c] + rand_offset(box_half[c]);
        pos[k] = box_ctr[k] + ($urandom_range(1) ? 1 : -1) *
                 (box_half[k] + longint'(s.radius) + longint'($urandom_range(2)) - 1);
      end else begin
        for (int c = 0; c < 3; c++)
          pos[c] = box_ctr[c] + rand_offset(box_half[c] + longint'(radius_cap) + 256);
      end
      s.x = 20'(pos[0]);
      s.y = 20'(pos[1]);
      s.z = 20'(pos[2]);
    end
    return s;
  endfunction

  task automatic send_sphere(sphere_beat_t s);
    int gap;
    gap = (steady_tx || $urandom_range(99) < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.tag, s.radius, s.z, s.y, s.x};
    s_axis_tlast  <= s.last;
    do @(posedge clk_i); while (!s_axis_tready);
    box_model.note_sphere(s);
  endtask

  // Drop valid and let the pipeline empty before touching the box
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (box_model.hits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_box(input logic [59:0] center, input logic [47:0] a0, a1, a2,
                          input logic [59:0] half);
    logic [63:0]        values [5];
    obs_pkg::cfg_reg_e  idx;
    values[0] = 64'(center);
    values[1] = 64'(a0);
    values[2] = 64'(a1);
    values[3] = 64'(a2);
    values[4] = 64'(half);
    idx = obs_pkg::RegCenter;
    for (int k = 0; k < 5; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= values[k];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      box_model.set_reg(idx, values[k]);
      idx = idx.next();
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    for (int c = 0; c < 3; c++) begin
      box_ctr[c]  = longint'($signed(center[20*c +: 20]));
      box_half[c] = longint'(half[20*c +: 20]);
    end
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        box_model.check_result(overlap_result_t'{m_axis_tdata[0], m_axis_tdata[16:1],
                                                 m_axis_tlast});
      if (stall_left == 0 && !steady_rx && $urandom_range(99) < 20) stall_left = pick_gap();
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    steady_tx     = 1'b0;
    steady_rx     = 1'b0;
    radius_cap    = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    for (int c = 0; c < 3; c++) begin
      box_ctr[c]  = 0;
      box_half[c] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset box: a single point at the origin
    send_sphere(mk_sphere(0, 0, 0, 0, 0, 1'b0));
    send_sphere(mk_sphere(1, 0, 0, 0, 1, 1'b1));
    send_sphere(mk_sphere(1, 0, 0, 1, 2, 1'b0));
    send_sphere(mk_sphere(0, -256, 0, 255, 3, 1'b1));
    send_sphere(mk_sphere(0, -256, 0, 256, 4, 1'b0));
    send_sphere(mk_sphere(0, 0, 768, 768, 5, 1'b0));
    send_sphere(mk_sphere(0, 0, 768, 767, 6, 1'b1));
    send_sphere(mk_sphere(-1, -1, -1, 1, 7, 1'b0));
    send_sphere(mk_sphere(-1, -1, -1, 2, 8, 1'b0));
    send_sphere(mk_sphere(0, 0, -524288, 'hFFFFF, 'hFFFF, 1'b1));
    send_sphere(mk_sphere(-524288, -524288, -524288, 'hFFFFF, 'hAAAA, 1'b0));
    send_sphere(mk_sphere(524287, 524287, 524287, 'hFFFFF, 'h5555, 1'b1));
    send_sphere(mk_sphere(524287, -524288, 0, 0, 'h8000, 1'b0));
    send_sphere(mk_sphere(0, 0, 0, 'hFFFFF, 'h0001, 1'b1));
    send_sphere(mk_sphere(1000, -2000, 3000, 3742, 'h1234, 1'b0));
    send_sphere(mk_sphere(1000, -2000, 3000, 3741, 'hFEDC, 1'b1));
    send_sphere(mk_sphere(-524288, 524287, -524288, 0, 0, 1'b1));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      steady_tx = (ph == 1) || ($urandom_range(3) == 0);
      steady_rx = (ph == 1) || ($urandom_range(3) == 0);
      case (ph)
        0: begin
          load_box(random_center(512), 48'h0000_0000_4000, 48'h0000_4000_0000,
                   48'h4000_0000_0000, random_half(200));
          radius_cap = 100 * 256;
        end
        1: begin
          pick_rotation();
          load_box(random_center(512), spun[0], spun[1], spun[2], random_half(300));
          radius_cap = 150 * 256;
        end
        2: begin
          // most positive center, axes at -2.0, widest box
          load_box({3{20'h7FFFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                   {3{20'hFFFFF}});
          radius_cap = 'hFFFFF;
        end
        3: begin
          load_box({3{20'h80000}}, {16'h7FFF, 16'h8000, 16'h7FFF},
                   48'($urandom) | (48'($urandom) << 32), 48'h0, 60'h0);
          radius_cap = 'hFFFFF;
        end
        4: begin
          // unnormalized axes, raw bits everywhere
          load_box(60'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   60'({$urandom, $urandom}));
          radius_cap = 'hFFFFF;
        end
        5: begin
          pick_rotation();
          load_box(random_center(1024), spun[0], spun[1], spun[2],
                   random_half(80) & {20'hFFFFF, 20'hFFFFF, 20'h0});
          radius_cap = 50 * 256;
        end
        default: begin
          load_box(60'h0, 48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                   60'h0);
          radius_cap = 4 * 256;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) send_sphere(random_sphere());
    end

    drain();
    if (box_model.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
